/* hdl/tgarle_pkg.sv */
// Shared types, register indexes and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

   localparam int PIXEL_COUNT_BITS_DEF = 32;
   localparam int CSR_INDEX_BITS       = 2;
   localparam int CSR_DATA_BITS        = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BYTES_PER_PIXEL = 2'd0,
      CSR_COMPRESSED_MODE = 2'd1,
      CSR_FRAME_PIXELS    = 2'd2
   } csr_index_type;

   localparam logic [2:0]  BPP_BGR          = 3'd3;
   localparam logic [2:0]  BPP_BGRA         = 3'd4;
   localparam logic        COMP_RLE         = 1'b1;
   localparam logic [31:0] FRAME_PIXELS_RST = 32'd1;

   localparam logic [7:0]  RUN_HDR_BIAS     = 8'd127;
   localparam logic [7:0]  OPAQUE_ALPHA     = 8'hFF;

   typedef struct packed {
      logic [2:0]  bytes_per_pixel;
      logic        compressed_mode;
      logic [31:0] frame_pixels;
   } cfg_type;

   typedef struct packed {
      logic       vld;
      logic [7:0] data;
   } byte_word_type;

endpackage

/* hdl/tgarle_cfg.sv */
// Configuration registers written through the plain write port.
module tgarle_cfg
   import tgarle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[2:0];
            CSR_COMPRESSED_MODE: cfg_in.compressed_mode = csr_wdata[0];
            CSR_FRAME_PIXELS:    cfg_in.frame_pixels    = csr_wdata[31:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= BPP_BGR;
         cfg_ff.compressed_mode <= COMP_RLE;
         cfg_ff.frame_pixels    <= FRAME_PIXELS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/tgarle_in_stage.sv */
// Input register: holds one accepted byte until the decode stage takes it.
module tgarle_in_stage
   import tgarle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          take,
   output byte_word_type in_word
);

   logic       vld_ff, vld_in;
   logic [7:0] data_ff;
   logic       accept;

   // stall only when the held word cannot move on this cycle
   assign req_stall = vld_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
      end
   end

   assign in_word.vld  = vld_ff;
   assign in_word.data = data_ff;

endmodule

/* hdl/tgarle_decode.sv */
// Packet and pixel decode: state update per byte and the result register.
module tgarle_decode
   import tgarle_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  byte_word_type in_word,
   output logic          take,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_red,
   output logic [7:0]    rsp_green,
   output logic [7:0]    rsp_blue,
   output logic [7:0]    rsp_alpha,
   output logic [7:0]    rsp_repeat_count,
   output logic          rsp_last_pixel
);

   localparam int PCB = PIXEL_COUNT_BITS;
   localparam logic [PCB-1:0] CNT_ONE = PCB'(1);

   logic           expect_header_ff, expect_header_in;
   logic           run_packet_ff, run_packet_in;
   logic [7:0]     ppl_ff, ppl_in;
   logic [1:0]     bip_ff, bip_in;
   logic [PCB-1:0] done_ff, done_in;
   logic [7:0]     color_ff [3];

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     red_ff, green_ff, blue_ff, alpha_ff, repeat_ff;
   logic           last_ff;

   logic           out_free;
   logic           four;
   logic [1:0]     last_idx;
   logic           is_header;
   logic           store_byte;
   logic           emit;
   logic [7:0]     b;
   logic [PCB-1:0] frame_raw, frame, remaining, rep_raw_w, rep_w;
   logic [7:0]     rep_raw;
   logic [7:0]     ppl_step;
   logic           last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = in_word.vld && out_free;

   always_comb begin
      b          = in_word.data;
      four       = (cfg.bytes_per_pixel == BPP_BGRA);
      last_idx   = four ? 2'd3 : 2'd2;
      is_header  = cfg.compressed_mode && expect_header_ff;
      store_byte = !is_header && (bip_ff < last_idx);
      emit       = take && !is_header && !store_byte;

      // frame size of zero counts as one pixel
      frame_raw = cfg.frame_pixels[PCB-1:0];
      frame     = (frame_raw == '0) ? CNT_ONE : frame_raw;
      remaining = (done_ff < frame) ? (frame - done_ff) : CNT_ONE;

      if (cfg.compressed_mode && run_packet_ff) begin
         rep_raw = (ppl_ff != 8'd0) ? ppl_ff : 8'd1;
      end else begin
         rep_raw = 8'd1;
      end
      rep_raw_w = PCB'(rep_raw);
      // clip a run to the pixels left in the frame
      rep_w     = (rep_raw_w > remaining) ? remaining : rep_raw_w;
      last      = (rep_raw_w >= remaining);

      if (run_packet_ff) begin
         ppl_step = 8'd0;
      end else if (ppl_ff != 8'd0) begin
         ppl_step = ppl_ff - 8'd1;
      end else begin
         ppl_step = 8'd0;
      end

      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      ppl_in           = ppl_ff;
      bip_in           = bip_ff;
      done_in          = done_ff;

      if (take) begin
         if (is_header) begin
            run_packet_in    = b[7];
            ppl_in           = b[7] ? (b - RUN_HDR_BIAS) : (b + 8'd1);
            expect_header_in = 1'b0;
            bip_in           = 2'd0;
         end else if (store_byte) begin
            bip_in = bip_ff + 2'd1;
         end else begin
            bip_in = 2'd0;
            if (cfg.compressed_mode) begin
               ppl_in = ppl_step;
               if (ppl_step == 8'd0) begin
                  expect_header_in = 1'b1;
               end
            end
            if (last) begin
               done_in          = '0;
               expect_header_in = 1'b1;
               ppl_in           = 8'd0;
               run_packet_in    = 1'b0;
            end else begin
               done_in = done_ff + rep_w;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         ppl_ff           <= 8'd0;
         bip_ff           <= 2'd0;
         done_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         ppl_ff           <= ppl_in;
         bip_ff           <= bip_in;
         done_ff          <= done_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && store_byte) begin
         color_ff[bip_ff] <= b;
      end
   end

   // stored order is B, G, R(, A)
   always_ff @(posedge clock) begin
      if (emit) begin
         red_ff    <= four ? color_ff[2] : b;
         green_ff  <= color_ff[1];
         blue_ff   <= color_ff[0];
         alpha_ff  <= four ? b : OPAQUE_ALPHA;
         repeat_ff <= rep_w[7:0];
         last_ff   <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_repeat_count = repeat_ff;
   assign rsp_last_pixel   = last_ff;

endmodule

/* hdl/tga_rle_pixel_decoder.sv */
// Top level of the TGA run-length pixel decoder.
// Bytes pass the input register; the one that ends a pixel loads the result register.
// Throughput: one byte per cycle while the result side does not stall; the input
// register holds one byte while a result waits; later bytes stall until it is taken.
// Reset (synchronous): clears packet, pixel and frame counters and the valid flags,
// and sets 3 bytes per pixel, compressed mode and a one-pixel frame.
module tga_rle_pixel_decoder
   import tgarle_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [7:0]                rsp_alpha,
   output logic [7:0]                rsp_repeat_count,
   output logic                      rsp_last_pixel
);

   cfg_type       cfg;
   byte_word_type in_word;
   logic          take;

   tgarle_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tgarle_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .take          (take),
      .in_word       (in_word)
   );

   tgarle_decode #(
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) u_decode (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_word          (in_word),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

/* hdl/tgarle_checker.sv */
// Port-level checks on the TGA run-length pixel decoder, bound to the top level.
module tgarle_checker
   import tgarle_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha,
   input logic [7:0] rsp_repeat_count,
   input logic       rsp_last_pixel
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_alpha) && $stable(rsp_repeat_count)
         && $stable(rsp_last_pixel))
      else $error("result word changed while stalled");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128)
      else $error("repeat count out of range");

   // a fresh result needs a preceding accepted input word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a preceding input word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs active after reset");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_red          (rsp_red),
   .rsp_green        (rsp_green),
   .rsp_blue         (rsp_blue),
   .rsp_alpha        (rsp_alpha),
   .rsp_repeat_count (rsp_repeat_count),
   .rsp_last_pixel   (rsp_last_pixel)
);

/* tb/tga_rle_pixel_decoder_tb.sv */
// Self-checking testbench for the TGA run-length pixel decoder against a pixel predictor.

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] repeat_count;
   logic       last_pixel;
} pixel_run_type;

// Pixel predictor plus the queue of result words still owed by the block.
class rle_scoreboard;
   bit [2:0]      bpp;
   bit            comp;
   bit [31:0]     frame_size;
   bit            awaiting_header;
   bit            in_run;
   bit [7:0]      pkt_left;
   bit [1:0]      byte_idx;
   bit [7:0]      stored[3];
   bit [31:0]     done_count;
   pixel_run_type expected_runs[$];
   int            mismatches;

   function new();
      bpp             = tgarle_pkg::BPP_BGR;
      comp            = tgarle_pkg::COMP_RLE;
      frame_size      = tgarle_pkg::FRAME_PIXELS_RST;
      awaiting_header = 1'b1;
      in_run          = 1'b0;
      pkt_left        = '0;
      byte_idx        = '0;
      done_count      = '0;
      mismatches      = 0;
      foreach (stored[i]) stored[i] = '0;
   endfunction

   function void set_reg(tgarle_pkg::csr_index_type idx, bit [31:0] v);
      case (idx)
         tgarle_pkg::CSR_BYTES_PER_PIXEL: bpp = v[2:0];
         tgarle_pkg::CSR_COMPRESSED_MODE: comp = v[0];
         tgarle_pkg::CSR_FRAME_PIXELS: frame_size = v;
         default: ;
      endcase
   endfunction

   // Advance the decoder by one byte; returns 1 when a result word is produced.
   function bit decode(bit [7:0] b, output pixel_run_type px);
      bit        four;
      bit [1:0]  last_idx;
      bit [31:0] frame;
      bit [31:0] remaining;
      bit [31:0] rep;
      four     = (bpp == tgarle_pkg::BPP_BGRA);
      last_idx = four ? 2'd3 : 2'd2;
      px       = '0;
      if (comp && awaiting_header) begin
         if (!b[7]) begin
            in_run   = 1'b0;
            pkt_left = b + 8'd1;
         end else begin
            in_run   = 1'b1;
            pkt_left = b - tgarle_pkg::RUN_HDR_BIAS;
         end
         awaiting_header = 1'b0;
         byte_idx        = '0;
         return 1'b0;
      end
      if (byte_idx < last_idx) begin
         stored[byte_idx] = b;
         byte_idx         = byte_idx + 2'd1;
         return 1'b0;
      end
      byte_idx = '0;
      frame    = (frame_size == 0) ? 32'd1 : frame_size;
      // once the count has reached a shrunk frame, one more pixel closes it
      remaining = (done_count < frame) ? frame - done_count : 32'd1;
      rep = 32'd1;
      if (comp) begin
         if (in_run) begin
            rep      = (pkt_left != 0) ? {24'd0, pkt_left} : 32'd1;
            pkt_left = '0;
         end else if (pkt_left > 0) begin
            pkt_left = pkt_left - 8'd1;
         end
         if (pkt_left == 0) awaiting_header = 1'b1;
      end
      if (rep > remaining) rep = remaining;
      px.red          = four ? stored[2] : b;
      px.green        = stored[1];
      px.blue         = stored[0];
      px.alpha        = four ? b : tgarle_pkg::OPAQUE_ALPHA;
      px.repeat_count = rep[7:0];
      if (rep >= remaining) begin
         // frame complete: drop whatever is left of the packet
         px.last_pixel   = 1'b1;
         done_count      = '0;
         awaiting_header = 1'b1;
         pkt_left        = '0;
         in_run          = 1'b0;
      end else begin
         done_count = done_count + rep;
      end
      return 1'b1;
   endfunction

   function void note_byte(bit [7:0] b);
      pixel_run_type px;
      if (decode(b, px)) expected_runs.push_back(px);
   endfunction

   function int outstanding();
      return expected_runs.size();
   endfunction

   function void flag(string what, pixel_run_type want, pixel_run_type got);
      if (mismatches < 10) begin
         $write("%s: expected rgba %02h %02h %02h %02h x%0d last %0b, ",
                what, want.red, want.green, want.blue, want.alpha, want.repeat_count,
                want.last_pixel);
         $display("got rgba %02h %02h %02h %02h x%0d last %0b",
                  got.red, got.green, got.blue, got.alpha, got.repeat_count,
                  got.last_pixel);
      end
      mismatches++;
   endfunction

   function void check_pixel(pixel_run_type got);
      pixel_run_type want;
      if (expected_runs.size() == 0) begin
         flag("unexpected result word", '0, got);
         return;
      end
      want = expected_runs.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.repeat_count !== want.repeat_count ||
          got.last_pixel !== want.last_pixel)
         flag("result word mismatch", want, got);
   endfunction
endclass

module tga_rle_pixel_decoder_tb;
   import tgarle_pkg::*;

   localparam int TARGET_BYTES   = 1100;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      csr_wr_en     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata     = '0;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_data_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic [7:0]                rsp_red;
   logic [7:0]                rsp_green;
   logic [7:0]                rsp_blue;
   logic [7:0]                rsp_alpha;
   logic [7:0]                rsp_repeat_count;
   logic                      rsp_last_pixel;

   rle_scoreboard pixel_board  = new();
   rle_scoreboard stream_model = new();

   bit tx_quiet     = 1'b0;
   bit rx_quiet     = 1'b0;
   bit hold_request = 1'b0;
   int rx_gap       = 0;
   int stuck_cycles = 0;
   int bytes_sent   = 0;
   int phase        = 0;
   int phase_len;

   tga_rle_pixel_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 94) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] next_byte();
      int r;
      if (stream_model.comp && stream_model.awaiting_header) begin
         r = $urandom_range(0, 19);
         case (r)
            0: return 8'd0;
            1: return 8'd127;
            2: return 8'd128;
            3: return 8'd255;
            4, 5, 6, 7, 8: return 8'($urandom_range(0, 3));
            9: return 8'($urandom_range(0, 127));
            10, 11, 12, 13, 14, 15: return 8'($urandom_range(128, 135));
            default: return 8'($urandom_range(128, 255));
         endcase
      end
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Input side: record accepted words; output side: check them.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) pixel_board.note_byte(req_data_byte);
         if (rsp_valid && !rsp_stall)
            pixel_board.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_alpha,
                                     rsp_repeat_count, rsp_last_pixel});
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: random stalls, quiet stretches, and one long hold on request.
   always @(negedge clock) begin
      if (hold_request) begin
         rx_gap       = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
      if (rx_gap > 0) begin
         rsp_stall <= 1'b1;
         rx_gap = rx_gap - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rx_quiet && $urandom_range(0, 3) == 0) rx_gap = gap_len();
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b);
      pixel_run_type scratch;
      int            pause;
      void'(stream_model.decode(b, scratch));
      csr_wr_en <= 1'b0;
      if (!tx_quiet && $urandom_range(0, 3) == 0) begin
         pause = gap_len();
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_seq(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      pixel_board.set_reg(idx, v);
      stream_model.set_reg(idx, v);
      @(negedge clock);
   endtask

   // Hold the sender until every owed word is out, then let the pipe settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pixel_board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic pick_config(input bit write_all);
      int r;
      if (write_all || $urandom_range(0, 1)) begin
         r = $urandom_range(0, 9);
         if (r < 4) write_reg(CSR_BYTES_PER_PIXEL, 32'(BPP_BGR));
         else if (r < 8) write_reg(CSR_BYTES_PER_PIXEL, 32'(BPP_BGRA));
         else if (r == 8) write_reg(CSR_BYTES_PER_PIXEL, $urandom_range(0, 2));
         else write_reg(CSR_BYTES_PER_PIXEL, $urandom_range(5, 7));
      end
      if (write_all || $urandom_range(0, 1))
         write_reg(CSR_COMPRESSED_MODE, 32'($urandom_range(0, 3) != 0));
      if (write_all || $urandom_range(0, 1)) begin
         r = $urandom_range(0, 19);
         if (r < 10) write_reg(CSR_FRAME_PIXELS, $urandom_range(1, 12));
         else if (r < 15) write_reg(CSR_FRAME_PIXELS, $urandom_range(13, 200));
         else if (r == 15) write_reg(CSR_FRAME_PIXELS, 32'd0);
         else if (r == 16) write_reg(CSR_FRAME_PIXELS, 32'hFFFF_FFFF);
         else if (r == 17) write_reg(CSR_FRAME_PIXELS, $urandom());
         else write_reg(CSR_FRAME_PIXELS, 32'd1);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one-pixel frame clips a 128-pixel run
      send_seq('{8'hFF, 8'h00, 8'h80, 8'hFF});
      drain_results();
      // frame size zero counts as one pixel; BGRA raw packet
      write_reg(CSR_BYTES_PER_PIXEL, 32'(BPP_BGRA));
      write_reg(CSR_FRAME_PIXELS, 32'd0);
      send_seq('{8'h00, 8'h12, 8'h34, 8'h56, 8'h78});
      drain_results();
      // huge frame: single run, then a long raw packet left unfinished
      write_reg(CSR_BYTES_PER_PIXEL, 32'(BPP_BGR));
      write_reg(CSR_FRAME_PIXELS, 32'hFFFF_FFFF);
      send_seq('{8'h80, 8'hAA, 8'h55, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF});
      drain_results();
      // shrink the frame to the pixel count, go uncompressed, stop mid-pixel
      write_reg(CSR_FRAME_PIXELS, 32'd2);
      write_reg(CSR_COMPRESSED_MODE, 32'd0);
      send_seq('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
      drain_results();
      // widen the pixel while one is half gathered
      write_reg(CSR_BYTES_PER_PIXEL, 32'(BPP_BGRA));
      send_seq('{8'h09, 8'h0A});

      while (bytes_sent < TARGET_BYTES) begin
         drain_results();
         pick_config(phase == 0);
         phase_len = (phase == 1) ? 150 : $urandom_range(20, 110);
         tx_quiet  = (phase == 1) || ($urandom_range(0, 3) == 0);
         // back up the result side while the sender keeps offering words
         if (phase == 1) hold_request = 1'b1;
         repeat (phase_len) send_byte(next_byte());
         bytes_sent += phase_len;
         phase++;
      end

      req_valid <= 1'b0;
      while (pixel_board.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pixel_board.mismatches + pixel_board.outstanding() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
hdl/tgarle_pkg.sv
hdl/tgarle_cfg.sv
hdl/tgarle_in_stage.sv
hdl/tgarle_decode.sv
hdl/tga_rle_pixel_decoder.sv
hdl/tgarle_checker.sv
tb/tga_rle_pixel_decoder_tb.sv
